FILE: hdl/gbr_pkg.sv
// Package with the shared types, codes and glyph size functions of the GBK glyph rasterizer.
`default_nettype none

package gbr_pkg;

    // Field widths.
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned ROW_W    = 6;
    localparam int unsigned BIT_W    = 3;
    localparam int unsigned INDEX_W  = 15;   // 190 * 125 + 189 fits in 15 bits
    localparam int unsigned OFFSET_W = 22;   // glyph index times at most 128 bytes

    // Stream payload widths, whole bytes.
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 96;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_SELECT  = 3'd0,
        CFG_OVERLAY_MODE = 3'd1,
        CFG_BASE_ADDR_12 = 3'd2,
        CFG_BASE_ADDR_16 = 3'd3,
        CFG_BASE_ADDR_24 = 3'd4,
        CFG_BASE_ADDR_32 = 3'd5,
        CFG_FG_COLOR     = 3'd6,
        CFG_BG_COLOR     = 3'd7
    } cfg_index_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_REQUEST = 1'b0,
        KIND_PIXEL   = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        SIZE_12 = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_24 = 2'd2,
        SIZE_32 = 2'd3
    } size_t;

    // GBK code range limits.
    localparam logic [CODE_W-1:0] HI_FIRST  = 8'h81;
    localparam logic [CODE_W-1:0] LO_FIRST  = 8'h40;
    localparam logic [CODE_W-1:0] LO_GAP    = 8'h7f;
    localparam logic [CODE_W-1:0] LO_SKIP   = 8'h41;
    localparam logic [CODE_W-1:0] CODE_BAD  = 8'hff;
    localparam logic [COUNT_W-1:0] GLYPHS_PER_ROW = 8'd190;

    // Glyph height in pixels for a size code.
    function automatic logic [ROW_W-1:0] glyph_height(input size_t size);
        logic [ROW_W-1:0] h;
        begin
            case (size)
                SIZE_12: h = 6'd12;
                SIZE_16: h = 6'd16;
                SIZE_24: h = 6'd24;
                default: h = 6'd32;
            endcase
            return h;
        end
    endfunction

    // Bytes per glyph for a size code.
    function automatic logic [COUNT_W-1:0] glyph_bytes(input size_t size);
        logic [COUNT_W-1:0] n;
        begin
            case (size)
                SIZE_12: n = 8'd24;
                SIZE_16: n = 8'd32;
                SIZE_24: n = 8'd72;
                default: n = 8'd128;
            endcase
            return n;
        end
    endfunction

    // Glyph index times bytes per glyph, built from shifts and at most one add.
    function automatic logic [OFFSET_W-1:0] glyph_offset(input logic [INDEX_W-1:0] idx,
                                                         input size_t size);
        logic [OFFSET_W-1:0] w;
        logic [OFFSET_W-1:0] r;
        begin
            w = OFFSET_W'(idx);
            case (size)
                SIZE_12: r = (w << 4) + (w << 3);
                SIZE_16: r = w << 5;
                SIZE_24: r = (w << 6) + (w << 3);
                default: r = w << 7;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gbk_glyph_rasterizer.sv
// Top level of the GBK glyph rasterizer: font address requests and glyph pixel expansion.
`default_nettype none

// The accepting edge loads the work register and a later step, once the output register has
// room, loads the output register, which puts the flash request of a start item on m_tdata.
// Throughput: one start item, or one font byte with no glyph open, per cycle; a font byte of
// an open glyph walks one bit per cycle, 1 to 8 bits, and every step waits for output room.
// Reset (rst_n low, asynchronous) empties both registers, closes any open glyph and loads the
// defaults: 16-pixel size, normal mode, bases zero, foreground 0x0000, background 0xffff.
module gbk_glyph_rasterizer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Item input.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: code_high, code_low, origin_x, origin_y, font_byte.
    input  wire logic [gbr_pkg::S_DATA_W-1:0]  s_tdata,
    // Fields: opcode.
    input  wire logic                          s_tuser,

    // Result output.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // Fields from bit 0 up: flash_address, byte_count, blank_glyph, pixel_x, pixel_y,
    // pixel_color, then zero fill.
    output logic [gbr_pkg::M_DATA_W-1:0]       m_tdata,
    // Fields: kind.
    output logic                               m_tuser,
    output logic                               m_tlast,

    // Register write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gbr_pkg::CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    gbr_pkg::size_t                   size_reg;
    logic                             overlay_reg;
    logic [gbr_pkg::ADDR_W-1:0]       base12_reg;
    logic [gbr_pkg::ADDR_W-1:0]       base16_reg;
    logic [gbr_pkg::ADDR_W-1:0]       base24_reg;
    logic [gbr_pkg::ADDR_W-1:0]       base32_reg;
    logic [gbr_pkg::COLOR_W-1:0]      fg_reg;
    logic [gbr_pkg::COLOR_W-1:0]      bg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= gbr_pkg::SIZE_16;
            overlay_reg <= 1'b0;
            base12_reg  <= '0;
            base16_reg  <= '0;
            base24_reg  <= '0;
            base32_reg  <= '0;
            fg_reg      <= '0;
            bg_reg      <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (gbr_pkg::cfg_index_t'(cfg_index))
                gbr_pkg::CFG_SIZE_SELECT:  size_reg    <= gbr_pkg::size_t'(cfg_data[1:0]);
                gbr_pkg::CFG_OVERLAY_MODE: overlay_reg <= cfg_data[0];
                gbr_pkg::CFG_BASE_ADDR_12: base12_reg  <= cfg_data;
                gbr_pkg::CFG_BASE_ADDR_16: base16_reg  <= cfg_data;
                gbr_pkg::CFG_BASE_ADDR_24: base24_reg  <= cfg_data;
                gbr_pkg::CFG_BASE_ADDR_32: base32_reg  <= cfg_data;
                gbr_pkg::CFG_FG_COLOR:     fg_reg      <= cfg_data[15:0];
                gbr_pkg::CFG_BG_COLOR:     bg_reg      <= cfg_data[15:0];
                default:                   size_reg    <= size_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Work register: the item currently being processed, plus the bit it
    // has reached when it is a font byte.
    // ------------------------------------------------------------------
    logic                             work_valid_reg, work_valid_next;
    gbr_pkg::opcode_t                 work_op_reg;
    logic [gbr_pkg::CODE_W-1:0]       work_hi_reg;
    logic [gbr_pkg::CODE_W-1:0]       work_lo_reg;
    logic [gbr_pkg::COORD_W-1:0]      work_x_reg;
    logic [gbr_pkg::COORD_W-1:0]      work_y_reg;
    logic [gbr_pkg::CODE_W-1:0]       work_byte_reg;
    logic [gbr_pkg::BIT_W-1:0]        work_bit_reg, work_bit_next;

    // Glyph drawing state.
    logic                             active_reg, active_next;
    logic [gbr_pkg::COORD_W-1:0]      column_x_reg, column_x_next;
    logic [gbr_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [gbr_pkg::COORD_W-1:0]      top_row_reg, top_row_next;
    logic [gbr_pkg::COUNT_W-1:0]      bytes_left_reg, bytes_left_next;

    // Output register.
    logic                             m_valid_reg, m_valid_next;
    logic [gbr_pkg::M_DATA_W-1:0]     m_data_reg, m_data_next;
    logic                             m_user_reg, m_user_next;
    logic                             m_last_reg, m_last_next;

    logic                             out_room;
    logic                             step;
    logic                             step_done;
    logic                             emit;
    logic                             s_accept;

    // Request path.
    logic                             blank;
    logic [gbr_pkg::CODE_W-1:0]       lo_adj;
    logic [gbr_pkg::CODE_W-2:0]       hi_adj;
    logic [gbr_pkg::INDEX_W-1:0]      glyph_idx;
    logic [gbr_pkg::ADDR_W-1:0]       base_sel;
    logic [gbr_pkg::ADDR_W-1:0]       req_addr;
    logic [gbr_pkg::COUNT_W-1:0]      req_count;

    // Pixel path.
    logic [gbr_pkg::ROW_W-1:0]        height;
    logic [gbr_pkg::CODE_W-1:0]       shifted;
    logic                             bit_set;
    logic [gbr_pkg::ROW_W-1:0]        row_inc;
    logic                             col_end;
    logic                             later_emit;
    logic [gbr_pkg::BIT_W:0]          later_pos;
    logic [gbr_pkg::ROW_W:0]          later_row;
    logic [gbr_pkg::COORD_W-1:0]      pix_y;
    logic [gbr_pkg::COLOR_W-1:0]      pix_color;

    // The output register can take a result when it is empty or being drained.
    assign out_room = !m_valid_reg || m_tready;
    assign step     = work_valid_reg && out_room;
    assign s_tready = !work_valid_reg || (step && step_done);
    assign s_accept = s_tvalid && s_tready;

    // Address of the glyph in font flash.
    always_comb
    begin
        blank = (work_hi_reg < gbr_pkg::HI_FIRST) || (work_hi_reg == gbr_pkg::CODE_BAD)
             || (work_lo_reg < gbr_pkg::LO_FIRST) || (work_lo_reg == gbr_pkg::CODE_BAD);
        lo_adj = (work_lo_reg < gbr_pkg::LO_GAP) ? (work_lo_reg - gbr_pkg::LO_FIRST)
                                                 : (work_lo_reg - gbr_pkg::LO_SKIP);
        hi_adj = 7'(work_hi_reg - gbr_pkg::HI_FIRST);
        // 190 * hi_adj = 128 * hi_adj + 64 * hi_adj - 2 * hi_adj.
        glyph_idx = (gbr_pkg::INDEX_W'(hi_adj) << 7) + (gbr_pkg::INDEX_W'(hi_adj) << 6)
                  - (gbr_pkg::INDEX_W'(hi_adj) << 1) + gbr_pkg::INDEX_W'(lo_adj);
        case (size_reg)
            gbr_pkg::SIZE_12: base_sel = base12_reg;
            gbr_pkg::SIZE_16: base_sel = base16_reg;
            gbr_pkg::SIZE_24: base_sel = base24_reg;
            default:          base_sel = base32_reg;
        endcase
        req_count = gbr_pkg::glyph_bytes(size_reg);
        req_addr  = blank ? '0
                          : base_sel + gbr_pkg::ADDR_W'(gbr_pkg::glyph_offset(glyph_idx,
                                                                              size_reg));
    end

    // One bit of the current font byte per step.
    always_comb
    begin
        height    = gbr_pkg::glyph_height(size_reg);
        shifted   = work_byte_reg << work_bit_reg;
        bit_set   = shifted[gbr_pkg::CODE_W-1];
        row_inc   = row_reg + 6'd1;
        col_end   = (row_inc >= height);
        pix_y     = top_row_reg + gbr_pkg::COORD_W'(row_reg);
        pix_color = bit_set ? fg_reg : bg_reg;

        // Does any later bit of this byte still give a pixel? A later bit j steps on is
        // walked when it lies in the byte and the column has not ended before it.
        later_emit = 1'b0;
        for (int j = 1; j < 8; j++)
        begin
            later_pos = {1'b0, work_bit_reg} + 4'(j);
            later_row = {1'b0, row_reg} + 7'(j);
            if ((later_pos < 4'd8) && (later_row < {1'b0, height})
                && (shifted[7 - j] || !overlay_reg))
            begin
                later_emit = 1'b1;
            end
        end
    end

    // Step control, state update and result formation.
    always_comb
    begin
        step_done       = 1'b1;
        emit            = 1'b0;
        work_bit_next   = work_bit_reg;
        active_next     = active_reg;
        column_x_next   = column_x_reg;
        row_next        = row_reg;
        top_row_next    = top_row_reg;
        bytes_left_next = bytes_left_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;

        if (work_op_reg == gbr_pkg::OP_START)
        begin
            emit = 1'b1;
            m_user_next = gbr_pkg::KIND_REQUEST;
            m_last_next = 1'b1;
            m_data_next = '0;
            m_data_next[31:0]  = req_addr;
            m_data_next[39:32] = req_count;
            m_data_next[40]    = blank;
            if (step)
            begin
                active_next     = 1'b1;
                column_x_next   = work_x_reg;
                top_row_next    = work_y_reg;
                row_next        = '0;
                bytes_left_next = req_count;
            end
        end
        else if (active_reg)
        begin
            step_done   = col_end || (work_bit_reg == 3'd7);
            emit        = bit_set || !overlay_reg;
            m_user_next = gbr_pkg::KIND_PIXEL;
            m_last_next = step_done || !later_emit;
            m_data_next = '0;
            m_data_next[56:41] = column_x_reg;
            m_data_next[72:57] = pix_y;
            m_data_next[88:73] = pix_color;
            if (step)
            begin
                work_bit_next = work_bit_reg + 3'd1;
                if (col_end)
                begin
                    row_next      = '0;
                    column_x_next = column_x_reg + 16'd1;
                end
                else
                begin
                    row_next = row_inc;
                end
                if (step_done)
                begin
                    bytes_left_next = bytes_left_reg - 8'd1;
                    if (bytes_left_next == '0)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end

        if (s_accept)
        begin
            work_bit_next = '0;
        end

        work_valid_next = s_accept || (work_valid_reg && !(step && step_done));

        if (step && emit)
        begin
            m_valid_next = 1'b1;
        end
        else
        begin
            m_valid_next = m_valid_reg && !m_tready;
            m_data_next  = m_data_reg;
            m_user_next  = m_user_reg;
            m_last_next  = m_last_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_bit_reg   <= '0;
            active_reg     <= 1'b0;
            column_x_reg   <= '0;
            row_reg        <= '0;
            top_row_reg    <= '0;
            bytes_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            work_bit_reg   <= work_bit_next;
            active_reg     <= active_next;
            column_x_reg   <= column_x_next;
            row_reg        <= row_next;
            top_row_reg    <= top_row_next;
            bytes_left_reg <= bytes_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            work_op_reg   <= gbr_pkg::opcode_t'(s_tuser);
            work_hi_reg   <= s_tdata[7:0];
            work_lo_reg   <= s_tdata[15:8];
            work_x_reg    <= s_tdata[31:16];
            work_y_reg    <= s_tdata[47:32];
            work_byte_reg <= s_tdata[55:48];
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
